// ===== rtl/rud_pkg.sv =====
// shared constants, state type and controller/datapath interface structs
package rud_pkg;

   localparam int WIDTH = 64;
   localparam int CNT_W = (WIDTH > 2) ? $clog2(WIDTH) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic publish;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== rtl/rud_ctrl.sv =====
// sequencing state machine and step counter for the divider
module rud_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rud_pkg::status_type status,
   output rud_pkg::cmd_type    cmd
);
   import rud_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (count_ff == '0) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = req_valid ? ST_RUN : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      cmd.publish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
         end
         ST_FINISH: begin
            req_ready   = status.out_free;
            cmd.publish = status.out_free;
            cmd.load    = status.out_free & req_valid;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // step counter
   always_comb begin
      count_in = count_ff;
      if (cmd.load) begin
         count_in = CNT_LAST;
      end else if (cmd.step && count_ff != '0) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> status.out_free)
      else $error("result published while output register occupied");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_RUN && count_ff == CNT_LAST))
      else $error("load did not start a full run");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && count_ff == '0) |=> state_ff == ST_FINISH)
      else $error("run did not end after last step");

endmodule

// ===== rtl/rud_dp.sv =====
// shift-subtract datapath with working registers and result register
module rud_dp (
   input  logic               clock,
   input  logic               reset,
   input  rud_pkg::cmd_type    cmd,
   output rud_pkg::status_type status,
   input  logic [63:0]        req_dividend,
   input  logic [63:0]        req_divisor,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_quotient,
   output logic [63:0]        rsp_remainder,
   output logic               rsp_divide_by_zero
);
   import rud_pkg::*;

   // working registers: dividend bits shift out the top, quotient bits in the bottom
   logic [WIDTH-1:0] numquo_ff, numquo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] den_ff;
   logic             dbz_ff;

   logic [63:0] quo_out_ff, rem_out_ff;
   logic        dbz_out_ff;
   logic        valid_ff, valid_in;

   logic [WIDTH-1:0] shifted;
   logic [WIDTH:0]   diff;
   logic             carry, fits;

   // one restoring step
   always_comb begin
      carry   = rem_ff[WIDTH-1];
      shifted = {rem_ff[WIDTH-2:0], numquo_ff[WIDTH-1]};
      diff    = {1'b0, shifted} - {1'b0, den_ff};
      fits    = carry | ~diff[WIDTH];
      rem_in    = fits ? diff[WIDTH-1:0] : shifted;
      numquo_in = {numquo_ff[WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         numquo_ff <= req_dividend[WIDTH-1:0];
         den_ff    <= req_divisor[WIDTH-1:0];
         rem_ff    <= '0;
         dbz_ff    <= (req_divisor[WIDTH-1:0] == '0);
      end else if (cmd.step) begin
         numquo_ff <= numquo_in;
         rem_ff    <= rem_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         quo_out_ff <= dbz_ff ? 64'd0 : 64'(numquo_ff);
         rem_out_ff <= dbz_ff ? 64'd0 : 64'(rem_ff);
         dbz_out_ff <= dbz_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.publish) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign status.out_free    = ~valid_ff | rsp_ready;
   assign rsp_valid          = valid_ff;
   assign rsp_quotient       = quo_out_ff;
   assign rsp_remainder      = rem_out_ff;
   assign rsp_divide_by_zero = dbz_out_ff;

   a_publish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid)
      else $error("published result not shown");

   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_quotient == '0 && rsp_remainder == '0))
      else $error("divide by zero result not cleared");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_quotient)
         && $stable(rsp_remainder) && $stable(rsp_divide_by_zero)))
      else $error("stalled response changed");

endmodule

// ===== rtl/restoring_unsigned_divider.sv =====
// top level of the restoring unsigned divider
//
// usage:
//  - request channel (req_valid/req_ready) carries one transaction holding
//    req_dividend and req_divisor; only the low WIDTH bits are used
//  - response channel (rsp_valid/rsp_ready) returns rsp_quotient,
//    rsp_remainder and rsp_divide_by_zero, one response per request
//  - a zero divisor gives quotient and remainder of zero with the flag set
// timing:
//  - one quotient bit per cycle from a single shared subtractor, so a
//    division takes WIDTH steps after the accept cycle
//  - back-to-back requests overlap the hand-off: the next
//    request is accepted in the same cycle the finished result is loaded
//    into the response register
// reset: synchronous, active high; clears the controller and rsp_valid
// stall: a held response sits in the output register while the next
//   division runs; the new result then waits until rsp_ready frees it
module restoring_unsigned_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_dividend,
   input  logic [63:0] req_divisor,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_quotient,
   output logic [63:0] rsp_remainder,
   output logic        rsp_divide_by_zero
);
   import rud_pkg::*;

   // command and status buses between controller and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: accept, step count, result hand-off
   rud_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // shift-subtract datapath plus response register
   rud_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule
